[hdl/swdhte_pkg.sv]
`timescale 1ns / 1ps

package swdhte_pkg;

    localparam int unsigned DATA_BITS = 32;
    localparam int unsigned REQ_BITS  = 8;
    localparam int unsigned ACK_BITS  = 3;
    localparam int unsigned CNT_BITS  = 8;

    localparam logic [7:0] IDLE_CYCLES_RESET = 8'd8;
    localparam logic [2:0] TURN_CYCLES_RESET = 3'd1;
    localparam logic [2:0] TURN_MIN          = 3'd1;
    localparam logic [2:0] TURN_MAX          = 3'd4;

    localparam logic [ACK_BITS-1:0] ACK_OK   = 3'b001;
    localparam logic [ACK_BITS-1:0] ACK_WAIT = 3'b010;

    // register index as decoded from paddr[2]
    localparam logic REG_IDLE_CYCLES = 1'b0;
    localparam logic REG_TURN_CYCLES = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_REQ     = 4'd1,
        PH_TRN_ACK = 4'd2,
        PH_ACK     = 4'd3,
        PH_RDATA   = 4'd4,
        PH_TRN_RD  = 4'd5,
        PH_TRN_WR  = 4'd6,
        PH_WDATA   = 4'd7,
        PH_TRN_END = 4'd8,
        PH_TAIL    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_WAIT   = 2'd1,
        ST_FAULT  = 2'd2,
        ST_PARITY = 2'd3
    } status_t;

    typedef struct packed {
        logic                 start_req;
        logic                 ap_access;
        logic                 mode;
        logic [1:0]           reg_addr;
        logic [DATA_BITS-1:0] write_data;
        logic                 swdio_in;
    } step_in_t;

    typedef struct packed {
        logic                 swdio_out;
        logic                 swdio_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [1:0]           status;
        logic [DATA_BITS-1:0] read_data;
    } step_out_t;

    function automatic status_t ack_status(input logic [ACK_BITS-1:0] ack);
        status_t st;
        if (ack == ACK_OK)
        begin
            st = ST_OK;
        end
        else if (ack == ACK_WAIT)
        begin
            st = ST_WAIT;
        end
        else
        begin
            st = ST_FAULT;
        end
        return st;
    endfunction

endpackage

[hdl/swdhte_in_if.sv]
`timescale 1ns / 1ps

interface swdhte_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic        ap_access;
    logic        mode;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;

    modport source (
        output valid, start_req, ap_access, mode, reg_addr, write_data, swdio_in,
        input  ready
    );

    modport sink (
        input  valid, start_req, ap_access, mode, reg_addr, write_data, swdio_in,
        output ready
    );
endinterface

[hdl/swdhte_out_if.sv]
`timescale 1ns / 1ps

interface swdhte_out_if;
    logic        valid;
    logic        ready;
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] read_data;

    modport source (
        output valid, swdio_out, swdio_drive, busy_res, done_res, status, read_data,
        input  ready
    );

    modport sink (
        input  valid, swdio_out, swdio_drive, busy_res, done_res, status, read_data,
        output ready
    );
endinterface

[hdl/swd_host_transaction_engine.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// cmd      in   valid/ready    start_req, ap_access, mode, reg_addr, write_data, swdio_in
// res      out  valid/ready    swdio_out, swdio_drive, busy_res, done_res, status, read_data
// apb      in   psel/penable   paddr, pwdata, pwrite -> prdata, pready
//
// One request per clock while res is not stalled: each request is one debug clock period, and its
// result sits in the output register on the next cycle.
// cmd.ready stays high while the output register is empty or being drained.
// Reset: phase idle, status ok, idle_cycles 8, turnaround_cycles 1.
// A stall on res holds the engine state and the output register.

module swd_host_transaction_engine
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    swdhte_in_if.sink    cmd,
    swdhte_out_if.source res
);

    logic [7:0] idle_cycles_reg;
    logic [2:0] turnaround_cycles_reg;
    logic       cfg_wr;

    logic                  step_en;
    swdhte_pkg::step_in_t  step_in;
    swdhte_pkg::step_out_t step_out;

    logic                  out_valid_reg;
    swdhte_pkg::step_out_t out_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles_reg       <= swdhte_pkg::IDLE_CYCLES_RESET;
            turnaround_cycles_reg <= swdhte_pkg::TURN_CYCLES_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                swdhte_pkg::REG_IDLE_CYCLES: idle_cycles_reg       <= pwdata[7:0];
                swdhte_pkg::REG_TURN_CYCLES: turnaround_cycles_reg <= pwdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            swdhte_pkg::REG_IDLE_CYCLES: prdata = {24'd0, idle_cycles_reg};
            swdhte_pkg::REG_TURN_CYCLES: prdata = {29'd0, turnaround_cycles_reg};
            default:                     prdata = '0;
        endcase
    end

    assign cmd.ready = !out_valid_reg || res.ready;
    assign step_en   = cmd.valid && cmd.ready;

    assign step_in.start_req  = cmd.start_req;
    assign step_in.ap_access  = cmd.ap_access;
    assign step_in.mode       = cmd.mode;
    assign step_in.reg_addr   = cmd.reg_addr;
    assign step_in.write_data = cmd.write_data;
    assign step_in.swdio_in   = cmd.swdio_in;

    swdhte_engine u_engine
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (step_en),
        .step_in           (step_in),
        .idle_cycles       (idle_cycles_reg),
        .turnaround_cycles (turnaround_cycles_reg),
        .step_out          (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_reg <= step_out;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.swdio_out   = out_reg.swdio_out;
    assign res.swdio_drive = out_reg.swdio_drive;
    assign res.busy_res    = out_reg.busy_res;
    assign res.done_res    = out_reg.done_res;
    assign res.status      = out_reg.status;
    assign res.read_data   = out_reg.read_data;

endmodule

[hdl/swdhte_engine.sv]
`timescale 1ns / 1ps

module swdhte_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  swdhte_pkg::step_in_t step_in,
    input  logic [7:0]           idle_cycles,
    input  logic [2:0]           turnaround_cycles,
    output swdhte_pkg::step_out_t step_out
);

    swdhte_pkg::phase_t                        phase_reg, phase_next;
    logic [swdhte_pkg::CNT_BITS-1:0]           bit_count_reg, bit_count_next;
    logic [swdhte_pkg::REQ_BITS-1:0]           request_reg, request_next;
    logic [swdhte_pkg::DATA_BITS-1:0]          data_reg, data_next;
    logic                                      parity_reg, parity_next;
    logic [swdhte_pkg::ACK_BITS-1:0]           ack_reg, ack_next;
    logic                                      rnw_reg, rnw_next;
    swdhte_pkg::status_t                       last_status_reg, last_status_next;

    logic [swdhte_pkg::CNT_BITS:0] bc_inc;
    logic [2:0]                    ta;
    logic                          turn_done;
    logic                          req_par;
    logic                          finish;
    swdhte_pkg::status_t           fin_status;
    logic                          o;
    logic                          drv;
    logic                          busy;

    always_comb
    begin
        if (turnaround_cycles < swdhte_pkg::TURN_MIN)
        begin
            ta = swdhte_pkg::TURN_MIN;
        end
        else if (turnaround_cycles > swdhte_pkg::TURN_MAX)
        begin
            ta = swdhte_pkg::TURN_MAX;
        end
        else
        begin
            ta = turnaround_cycles;
        end
    end

    assign bc_inc    = {1'b0, bit_count_reg} + 9'd1;
    assign turn_done = (bc_inc >= {6'd0, ta});
    assign req_par   = step_in.ap_access ^ step_in.mode ^ step_in.reg_addr[0]
                       ^ step_in.reg_addr[1];

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bc_inc[swdhte_pkg::CNT_BITS-1:0];
        request_next     = request_reg;
        data_next        = data_reg;
        parity_next      = parity_reg;
        ack_next         = ack_reg;
        rnw_next         = rnw_reg;
        last_status_next = last_status_reg;
        finish           = 1'b0;
        fin_status       = swdhte_pkg::ST_OK;
        o                = 1'b0;
        drv              = 1'b0;
        busy             = 1'b1;

        case (phase_reg)
            swdhte_pkg::PH_IDLE:
            begin
                drv = 1'b1;
                if (step_in.start_req)
                begin
                    // start, APnDP, RnW, A2, A3, parity, stop, park
                    request_next = {1'b1, 1'b0, req_par, step_in.reg_addr,
                                    step_in.mode, step_in.ap_access, 1'b1};
                    rnw_next       = step_in.mode;
                    data_next      = step_in.write_data;
                    parity_next    = 1'b0;
                    ack_next       = '0;
                    o              = 1'b1;
                    bit_count_next = 8'd1;
                    phase_next     = swdhte_pkg::PH_REQ;
                end
                else
                begin
                    busy           = 1'b0;
                    bit_count_next = bit_count_reg;
                end
            end
            swdhte_pkg::PH_REQ:
            begin
                drv = 1'b1;
                o   = request_reg[bit_count_reg[2:0]];
                if (bc_inc >= 9'(swdhte_pkg::REQ_BITS))
                begin
                    bit_count_next = '0;
                    phase_next     = swdhte_pkg::PH_TRN_ACK;
                end
            end
            swdhte_pkg::PH_TRN_ACK:
            begin
                if (turn_done)
                begin
                    bit_count_next = '0;
                    phase_next     = swdhte_pkg::PH_ACK;
                end
            end
            swdhte_pkg::PH_ACK:
            begin
                if (bit_count_reg < 8'(swdhte_pkg::ACK_BITS))
                begin
                    ack_next[bit_count_reg[1:0]] = step_in.swdio_in;
                end
                if (bc_inc >= 9'(swdhte_pkg::ACK_BITS))
                begin
                    bit_count_next = '0;
                    if (swdhte_pkg::ack_status(ack_next) == swdhte_pkg::ST_OK)
                    begin
                        if (rnw_reg)
                        begin
                            data_next   = '0;
                            parity_next = 1'b0;
                            phase_next  = swdhte_pkg::PH_RDATA;
                        end
                        else
                        begin
                            phase_next = swdhte_pkg::PH_TRN_WR;
                        end
                    end
                    else
                    begin
                        phase_next = swdhte_pkg::PH_TRN_END;
                    end
                end
            end
            swdhte_pkg::PH_RDATA:
            begin
                if (bit_count_reg < 8'(swdhte_pkg::DATA_BITS))
                begin
                    data_next[bit_count_reg[4:0]] = step_in.swdio_in;
                end
                parity_next = parity_reg ^ step_in.swdio_in;
                if (bc_inc >= 9'(swdhte_pkg::DATA_BITS + 1))
                begin
                    bit_count_next = '0;
                    phase_next     = swdhte_pkg::PH_TRN_RD;
                end
            end
            swdhte_pkg::PH_TRN_RD:
            begin
                if (turn_done)
                begin
                    bit_count_next = '0;
                    if (parity_reg)
                    begin
                        finish     = 1'b1;
                        fin_status = swdhte_pkg::ST_PARITY;
                    end
                    else if (idle_cycles == 8'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = swdhte_pkg::PH_TAIL;
                    end
                end
            end
            swdhte_pkg::PH_TRN_WR:
            begin
                if (turn_done)
                begin
                    bit_count_next = '0;
                    parity_next    = 1'b0;
                    phase_next     = swdhte_pkg::PH_WDATA;
                end
            end
            swdhte_pkg::PH_WDATA:
            begin
                drv = 1'b1;
                if (bit_count_reg < 8'(swdhte_pkg::DATA_BITS))
                begin
                    o           = data_reg[bit_count_reg[4:0]];
                    parity_next = parity_reg ^ o;
                end
                else
                begin
                    o = parity_reg;
                end
                if (bc_inc >= 9'(swdhte_pkg::DATA_BITS + 1))
                begin
                    bit_count_next = '0;
                    if (idle_cycles == 8'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = swdhte_pkg::PH_TAIL;
                    end
                end
            end
            swdhte_pkg::PH_TRN_END:
            begin
                if (turn_done)
                begin
                    finish     = 1'b1;
                    fin_status = swdhte_pkg::ack_status(ack_reg);
                end
            end
            swdhte_pkg::PH_TAIL:
            begin
                drv = 1'b1;
                if (bc_inc >= {1'b0, idle_cycles})
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next     = swdhte_pkg::PH_IDLE;
                bit_count_next = '0;
                drv            = 1'b1;
                busy           = 1'b0;
            end
        endcase

        if (finish)
        begin
            last_status_next = fin_status;
            phase_next       = swdhte_pkg::PH_IDLE;
            bit_count_next   = '0;
        end

        step_out.swdio_out   = o;
        step_out.swdio_drive = drv;
        step_out.busy_res    = busy;
        step_out.done_res    = finish;
        step_out.status      = last_status_next;
        step_out.read_data   = (finish && rnw_reg &&
                                (fin_status == swdhte_pkg::ST_OK ||
                                 fin_status == swdhte_pkg::ST_PARITY))
                               ? data_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= swdhte_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            request_reg     <= '0;
            data_reg        <= '0;
            parity_reg      <= 1'b0;
            ack_reg         <= '0;
            rnw_reg         <= 1'b0;
            last_status_reg <= swdhte_pkg::ST_OK;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            request_reg     <= request_next;
            data_reg        <= data_next;
            parity_reg      <= parity_next;
            ack_reg         <= ack_next;
            rnw_reg         <= rnw_next;
            last_status_reg <= last_status_next;
        end
    end

endmodule
